// File: rtl/xcfd_pkg.sv
// Shared types and constants of the XOR-checked frame deframer.
package xcfd_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam logic [7:0] SYNC_RESET = 8'd126;
    localparam logic [6:0] DEPTH_LEN  = 7'(BUFFER_DEPTH);
    localparam logic [7:0] DEPTH_BYTE = 8'(BUFFER_DEPTH);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_chan;    // take channel byte, seed check
        logic ld_type;    // take type byte
        logic ld_len;     // take length byte, clear payload position
        logic wr_pay;     // store payload byte, advance position
        logic clr_idx;    // restart readout index
        logic rd_req;     // read store at readout index
        logic ld_single;  // load the single-result form into the output
        logic ld_stream;  // load one payload result into the output
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sync_hit;
        logic len_zero;
        logic pay_done;
        logic chk_ok;
        logic stored_zero;
        logic idx_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/xcfd_ctrl.sv
// Frame parse and readout state machine.
module xcfd_ctrl
    import xcfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_HUNT = 3'd0;
    localparam logic [2:0] S_CHAN = 3'd1;
    localparam logic [2:0] S_TYPE = 3'd2;
    localparam logic [2:0] S_LEN  = 3'd3;
    localparam logic [2:0] S_PAY  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    always_comb begin
        unique case (r_state)
            S_HUNT, S_CHAN, S_TYPE, S_LEN, S_PAY: o_ready = 1'b1;
            S_CHK:                                o_ready = i_sts.out_free;
            default:                              o_ready = 1'b0;
        endcase
    end

    assign accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (accept && i_sts.sync_hit) n_state = S_CHAN;
            end
            S_CHAN: begin
                if (accept) begin
                    o_cmd.ld_chan = 1'b1;
                    n_state       = S_TYPE;
                end
            end
            S_TYPE: begin
                if (accept) begin
                    o_cmd.ld_type = 1'b1;
                    n_state       = S_LEN;
                end
            end
            S_LEN: begin
                if (accept) begin
                    o_cmd.ld_len = 1'b1;
                    n_state      = i_sts.len_zero ? S_CHK : S_PAY;
                end
            end
            S_PAY: begin
                if (accept) begin
                    o_cmd.wr_pay = 1'b1;
                    if (i_sts.pay_done) n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (accept) begin
                    if (!i_sts.chk_ok || i_sts.stored_zero) begin
                        o_cmd.ld_single = 1'b1;
                        n_state         = S_HUNT;
                    end else begin
                        o_cmd.clr_idx = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_req = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_stream = 1'b1;
                    n_state         = i_sts.idx_last ? S_HUNT : S_RD;
                end
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.ld_single || o_cmd.ld_stream) |-> i_sts.out_free)
        else $error("output loaded while occupied");

    a_read_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_OUT))
        else $error("store read not followed by output load");

    a_single_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_single |=> (r_state == S_HUNT))
        else $error("single result did not return to hunting");

    a_no_input_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_idx |=> !o_ready ##1 !o_ready)
        else $error("input taken during readout");

endmodule

// File: rtl/xcfd_dp.sv
// Header registers, check accumulator, payload store and output register.
module xcfd_dp
    import xcfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic [7:0]           i_sync_value,
    input  logic [7:0]           i_rx_byte,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [7:0]           o_channel,
    output logic [7:0]           o_frame_type,
    output logic [7:0]           o_declared_length,
    output logic [6:0]           o_stored_length,
    output logic [5:0]           o_byte_index,
    output logic [7:0]           o_data_byte,
    output logic                 o_has_data,
    output logic                 o_crc_ok,
    output logic                 o_last
);

    logic [7:0]        r_sync;
    logic [7:0]        r_chan;
    logic [7:0]        r_type;
    logic [7:0]        r_len;
    logic [7:0]        r_pos;
    logic [7:0]        r_acc;
    logic [ADDR_W-1:0] r_idx;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_mem [BUFFER_DEPTH];
    logic              r_o_valid;
    logic [6:0]        stored_len;
    logic [8:0]        pos_next;

    assign stored_len = (r_len > DEPTH_BYTE) ? DEPTH_LEN : r_len[6:0];
    assign pos_next   = {1'b0, r_pos} + 9'd1;

    always_comb begin
        o_sts.sync_hit    = (i_rx_byte == r_sync);
        o_sts.len_zero    = (i_rx_byte == 8'd0);
        o_sts.pay_done    = (pos_next >= {1'b0, r_len});
        o_sts.chk_ok      = (i_rx_byte == r_acc);
        o_sts.stored_zero = (stored_len == 7'd0);
        o_sts.idx_last    = ((7'(r_idx) + 7'd1) == stored_len);
        o_sts.out_free    = !r_o_valid || i_ready;
    end

    // Configuration and frame control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= SYNC_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) r_sync <= i_sync_value;
            if (i_cmd.ld_single || i_cmd.ld_stream) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Header capture, check accumulation and readout index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_chan) begin
            r_chan <= i_rx_byte;
            r_acc  <= i_rx_byte;
        end
        if (i_cmd.ld_type) begin
            r_type <= i_rx_byte;
            r_acc  <= r_acc ^ i_rx_byte;
        end
        if (i_cmd.ld_len) begin
            r_len <= i_rx_byte;
            r_acc <= r_acc ^ i_rx_byte;
            r_pos <= 8'd0;
        end
        if (i_cmd.wr_pay) begin
            r_acc <= r_acc ^ i_rx_byte;
            r_pos <= pos_next[7:0];
        end
        if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.ld_stream) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Payload store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pay && (r_pos < DEPTH_BYTE)) begin
            r_mem[r_pos[ADDR_W-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_req) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_single || i_cmd.ld_stream) begin
            o_channel         <= r_chan;
            o_frame_type      <= r_type;
            o_declared_length <= r_len;
            o_stored_length   <= stored_len;
            o_last            <= i_cmd.ld_single || o_sts.idx_last;
        end
        if (i_cmd.ld_single) begin
            o_byte_index <= 6'd0;
            o_data_byte  <= 8'd0;
            o_has_data   <= 1'b0;
            o_crc_ok     <= o_sts.chk_ok;
        end else if (i_cmd.ld_stream) begin
            o_byte_index <= 6'(r_idx);
            o_data_byte  <= r_rd_data;
            o_has_data   <= 1'b1;
            o_crc_ok     <= 1'b1;
        end
    end

    assign o_valid = r_o_valid;

endmodule

// File: rtl/xor_checked_frame_deframer.sv
// Top level of the XOR-checked frame deframer.
//
// Input channel (i_valid/o_ready, i_rx_byte): one received byte per
// transaction. Frames are sync, channel, type, length, payload, check byte;
// the check byte is the XOR of channel, type, length and all payload bytes.
// Header and payload bytes are taken one per cycle. The check byte is taken
// once the output register is free.
// Output channel (o_valid/i_ready): a good frame yields one transaction per
// stored payload byte (at most BUFFER_DEPTH), o_last on the final one; a
// zero-length frame or a check failure yields one transaction with
// o_has_data clear. Payload readout takes a store read, then an output load,
// per result; the input is held from the check byte until the last result is
// loaded. The first result passes through the read state, the store read
// register and the output register after the check byte is accepted.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_sync_value): sets the
// sync byte; always ready.
// Reset (synchronous, active low) returns to hunting for sync, sets the
// sync byte to 0x7E and empties the output register.
// When the receiver stalls, the output register holds its transaction and
// readout pauses; header and payload bytes of the next frame still flow outside a payload readout.
module xor_checked_frame_deframer
    import xcfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_sync_value,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_channel,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_declared_length,
    output logic [6:0] o_stored_length,
    output logic [5:0] o_byte_index,
    output logic [7:0] o_data_byte,
    output logic       o_has_data,
    output logic       o_crc_ok,
    output logic       o_last
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // Parse sequencing and readout control.
    xcfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Header, check, store and output register.
    xcfd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr          (i_cfg_valid),
        .i_sync_value      (i_sync_value),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_channel         (o_channel),
        .o_frame_type      (o_frame_type),
        .o_declared_length (o_declared_length),
        .o_stored_length   (o_stored_length),
        .o_byte_index      (o_byte_index),
        .o_data_byte       (o_data_byte),
        .o_has_data        (o_has_data),
        .o_crc_ok          (o_crc_ok),
        .o_last            (o_last)
    );

endmodule

// File: bench/tb_xor_checked_frame_deframer.sv
// Self-checking testbench of the XOR-checked frame deframer: directed and random frames.
module tb_xor_checked_frame_deframer;
    import xcfd_pkg::*;

    // Stop the run after this many cycles without any transaction.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to hold before a sync write and after the last result.
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    // Frame bytes per sync setting in the random part.
    localparam int BYTES_PER_SETTING = 120;
    localparam int NUM_SETTINGS      = 4;

    // Parser states of the predictor.
    typedef enum logic [2:0] {
        RX_HUNT,
        RX_CHAN,
        RX_TYPE,
        RX_LEN,
        RX_PAYLOAD,
        RX_CHECK
    } rx_state_e;

    // One result transaction, field for field as on the output ports.
    typedef struct packed {
        logic [7:0] channel;
        logic [7:0] frame_type;
        logic [7:0] declared_length;
        logic [6:0] stored_length;
        logic [5:0] byte_index;
        logic [7:0] data_byte;
        logic       has_data;
        logic       crc_ok;
        logic       last;
    } frame_result_t;

    // One row of the directed part: the byte to send and, where the result can be
    // read off at a glance, the single result it must produce.
    typedef struct packed {
        logic [7:0]    rx;
        logic          typed;
        frame_result_t res;
    } stim_row_t;

    localparam int NUM_DIRECTED = 25;
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // zero-length frame right after reset, all header bytes zero, good check
        '{8'h7E, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 7'd0, 6'd0, 8'h00, 1'b0, 1'b1, 1'b1}},
        // bytes while hunting: ignored, no result
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        // zero-length frame with all-ones channel and type and a wrong check byte
        '{8'h7E, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, '{8'hFF, 8'hFF, 8'h00, 7'd0, 6'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
        // good two-byte frame carrying the payload extremes
        '{8'h7E, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        '{8'hA5, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        // one-byte frame with a wrong check: header still reported
        '{8'h7E, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h01, 8'h02, 8'h01, 7'd1, 6'd0, 8'h00, 1'b0, 1'b0, 1'b1}}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_sync_value;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_channel;
    logic [7:0] o_frame_type;
    logic [7:0] o_declared_length;
    logic [6:0] o_stored_length;
    logic [5:0] o_byte_index;
    logic [7:0] o_data_byte;
    logic       o_has_data;
    logic       o_crc_ok;
    logic       o_last;

    xor_checked_frame_deframer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_sync_value      (i_sync_value),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_channel         (o_channel),
        .o_frame_type      (o_frame_type),
        .o_declared_length (o_declared_length),
        .o_stored_length   (o_stored_length),
        .o_byte_index      (o_byte_index),
        .o_data_byte       (o_data_byte),
        .o_has_data        (o_has_data),
        .o_crc_ok          (o_crc_ok),
        .o_last            (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: a private copy of the parser, the payload buffer and the sync byte.
    rx_state_e  rx_state;
    logic [7:0] sync_byte;
    logic [7:0] frm_chan;
    logic [7:0] frm_type;
    logic [7:0] frm_len;
    logic [7:0] pay_cnt;
    logic [7:0] xor_sum;
    logic [7:0] pay_mem [BUFFER_DEPTH];

    // Results owed by the block, oldest first, and those of the byte just taken.
    frame_result_t pending_results [$];
    frame_result_t step_results [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int frame_bytes   = 0;
    int frames_sent   = 0;
    int bad_checks    = 0;
    int max_len_seen  = 0;
    int idle_cycles   = 0;
    int burst_left    = 0;
    int rdy_hold      = 0;

    // Advance the predictor by one received byte; queue what the byte completes.
    function automatic void deframe_step(input logic [7:0] b);
        frame_result_t r;
        logic [6:0]    kept;
        step_results.delete();
        case (rx_state)
            RX_HUNT: begin
                if (b == sync_byte) rx_state = RX_CHAN;
            end
            RX_CHAN: begin
                frm_chan = b;
                xor_sum  = b;
                rx_state = RX_TYPE;
            end
            RX_TYPE: begin
                frm_type = b;
                xor_sum  = xor_sum ^ b;
                rx_state = RX_LEN;
            end
            RX_LEN: begin
                frm_len  = b;
                xor_sum  = xor_sum ^ b;
                pay_cnt  = 8'd0;
                rx_state = (b == 8'd0) ? RX_CHECK : RX_PAYLOAD;
            end
            RX_PAYLOAD: begin
                // bytes past the buffer still count toward the check
                if (pay_cnt < DEPTH_BYTE) pay_mem[pay_cnt[ADDR_W-1:0]] = b;
                pay_cnt = pay_cnt + 8'd1;
                xor_sum = xor_sum ^ b;
                if (pay_cnt >= frm_len) rx_state = RX_CHECK;
            end
            RX_CHECK: begin
                kept = (frm_len > DEPTH_BYTE) ? DEPTH_LEN : frm_len[6:0];
                r = '0;
                r.channel         = frm_chan;
                r.frame_type      = frm_type;
                r.declared_length = frm_len;
                r.stored_length   = kept;
                r.last            = 1'b1;
                if (b != xor_sum) begin
                    step_results.push_back(r);
                end else if (kept == 7'd0) begin
                    r.crc_ok = 1'b1;
                    step_results.push_back(r);
                end else begin
                    r.crc_ok   = 1'b1;
                    r.has_data = 1'b1;
                    for (int k = 0; k < int'(kept); k++) begin
                        r.byte_index = 6'(k);
                        r.data_byte  = pay_mem[k];
                        r.last       = (k == int'(kept) - 1);
                        step_results.push_back(r);
                    end
                end
                rx_state = RX_HUNT;
            end
            default: rx_state = RX_HUNT;
        endcase
    endfunction

    // Send one byte after a random gap, hold it until accepted, then predict.
    // Typed rows replace the predicted results with the ones given in the row.
    task automatic push_byte(input logic [7:0] b, input logic typed,
                             input frame_result_t typed_res);
        int gap;
        int r;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                // start a stretch with no sender idling
                burst_left = $urandom_range(20, 80);
                gap = 0;
            end else if (r < 55) begin
                gap = 0;
            end else if (r < 92) begin
                gap = $urandom_range(1, 3);
            end else begin
                gap = $urandom_range(8, 40);
            end
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        deframe_step(b);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    // Drop valid and hold the sender until every owed result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the sync byte through the configuration channel; mirror it in the predictor.
    task automatic write_sync(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_sync_value <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sync_byte = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one frame with random content. A negative length picks one at random,
    // mostly short. Some frames get noise in front or a corrupted check byte.
    task automatic send_frame(input int forced_len);
        logic [7:0] chan;
        logic [7:0] ftype;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         r;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) begin
                push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                frame_bytes++;
            end
        end
        if (forced_len >= 0) begin
            len = 8'(forced_len);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = 8'($urandom_range(0, 8));
            else if (r < 97) len = 8'($urandom_range(9, 64));
            else             len = 8'($urandom_range(65, 255));
        end
        chan  = 8'($urandom_range(0, 255));
        ftype = 8'($urandom_range(0, 255));
        sum   = chan ^ ftype ^ len;
        push_byte(sync_byte, 1'b0, '0);
        push_byte(chan, 1'b0, '0);
        push_byte(ftype, 1'b0, '0);
        push_byte(len, 1'b0, '0);
        for (int i = 0; i < int'(len); i++) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum ^ b;
            push_byte(b, 1'b0, '0);
        end
        if ($urandom_range(0, 99) < 15) begin
            sum = sum ^ 8'($urandom_range(1, 255));
            bad_checks++;
        end
        push_byte(sum, 1'b0, '0);
        frame_bytes += 5 + int'(len);
        frames_sent++;
        if (int'(len) > max_len_seen) max_len_seen = int'(len);
    endtask

    // Receiver: ready in held runs; stalls mostly short, a few long, and long
    // runs of plain ready in between.
    always @(negedge i_clk) begin
        if (rdy_hold > 0) begin
            rdy_hold--;
        end else if ($urandom_range(0, 99) < 60) begin
            i_ready  <= 1'b1;
            rdy_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(0, 20);
        end else begin
            i_ready  <= 1'b0;
            rdy_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(10, 50);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare every result transaction with the oldest owed result.
    always @(posedge i_clk) begin
        frame_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no owed result: channel 0x%0h index %0d",
                       o_channel, o_byte_index);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                check_field("channel", want.channel, o_channel);
                check_field("frame_type", want.frame_type, o_frame_type);
                check_field("declared_length", want.declared_length, o_declared_length);
                check_field("stored_length", want.stored_length, o_stored_length);
                check_field("byte_index", want.byte_index, o_byte_index);
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("has_data", want.has_data, o_has_data);
                check_field("crc_ok", want.crc_ok, o_crc_ok);
                check_field("last", want.last, o_last);
            end
        end
    end

    // Watchdog: count cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results owed",
                     idle_cycles, pending_results.size());
            $display("[xor_checked_frame_deframer] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0] sync_setting [NUM_SETTINGS];
        int         forced_len   [NUM_SETTINGS];
        int         phase_frames;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_rx_byte    = 8'h00;
        i_cfg_valid  = 1'b0;
        i_sync_value = 8'h00;
        // predictor reset state
        rx_state  = RX_HUNT;
        sync_byte = SYNC_RESET;
        frm_chan  = 8'h00;
        frm_type  = 8'h00;
        frm_len   = 8'h00;
        pay_cnt   = 8'h00;
        xor_sum   = 8'h00;
        foreach (pay_mem[i]) pay_mem[i] = 8'h00;
        // sync settings: reset value, both extremes, one random; each with a
        // boundary length forced into its first frame
        sync_setting = '{SYNC_RESET, 8'h00, 8'hFF, 8'($urandom_range(1, 254))};
        forced_len   = '{int'(BUFFER_DEPTH), int'(BUFFER_DEPTH) + 1, 255, 1};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: walk the rows under the reset sync byte.
        foreach (DIRECTED_ROWS[i])
            push_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

        // Random part: well-formed frames with random content, noise and bad checks.
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            if (p > 0) begin
                // finish any frame left open by noise, then drain and settle
                while (rx_state != RX_HUNT)
                    push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                drain_results();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                write_sync(sync_setting[p]);
            end
            phase_frames = 0;
            send_frame(forced_len[p]);
            while (frame_bytes < (p + 1) * BYTES_PER_SETTING) begin
                send_frame(-1);
                phase_frames++;
                // hold the sender once per setting until the output side is empty
                if (phase_frames == 6) drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d frames (%0d with a bad check, longest length %0d) in %0d bytes",
                 frames_sent, bad_checks, max_len_seen, frame_bytes + NUM_DIRECTED);
        $display("under %0d sync settings; %0d results checked, %0d mismatches",
                 NUM_SETTINGS, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("[xor_checked_frame_deframer] OK");
        end else begin
            $display("[xor_checked_frame_deframer] ERROR");
        end
        $finish;
    end

endmodule
